[rtl/tccr_pkg.sv]
// Shared types, constants and the 5x7 glyph table of the text console cell renderer.
// Used by every module of the block; no dependencies of its own.
package tccr_pkg;

    localparam int LEFT_MARGIN_PX = 12;
    localparam int TOP_MARGIN_PX  = 56;
    localparam int CELL_W         = 8;
    localparam int CELL_H         = 10;
    localparam int GLYPH_ROWS     = 7;
    localparam int GLYPH_COLS     = 5;
    localparam int MAX_LINES      = 10;
    localparam int NUM_LINES      = (CELL_H < MAX_LINES) ? CELL_H : MAX_LINES;

    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [1:0] KIND_DRAW   = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_t;

    typedef struct packed {
        logic       enable;
        logic [7:0] column_count;
        logic [7:0] row_count;
    } cfg_t;

    // One queued console operation; clear excludes scroll and draw.
    typedef struct packed {
        logic       clear;
        logic       scroll;
        logic       draw;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] code;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [3:0]  line_index;
        logic [4:0]  row_bits;
        logic        last;
    } result_t;

    function automatic glyph_t pk(input logic [4:0] r0, input logic [4:0] r1,
                                  input logic [4:0] r2, input logic [4:0] r3,
                                  input logic [4:0] r4, input logic [4:0] r5,
                                  input logic [4:0] r6);
        glyph_t g;
        g[0] = r0; g[1] = r1; g[2] = r2; g[3] = r3;
        g[4] = r4; g[5] = r5; g[6] = r6;
        return g;
    endfunction

    // Bytes without a glyph draw as a space (all rows blank).
    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        case (code)
            8'h2D: g = pk(5'h00, 5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00);
            8'h2E: g = pk(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C);
            8'h3A: g = pk(5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00);
            8'h2F: g = pk(5'h02, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08, 5'h10);
            8'h3D: g = pk(5'h00, 5'h1E, 5'h00, 5'h1E, 5'h00, 5'h00, 5'h00);
            8'h5F: g = pk(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F);
            8'h30: g = pk(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
            8'h31: g = pk(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
            8'h32: g = pk(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F);
            8'h33: g = pk(5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E);
            8'h34: g = pk(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02);
            8'h35: g = pk(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E);
            8'h36: g = pk(5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E);
            8'h37: g = pk(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08);
            8'h38: g = pk(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E);
            8'h39: g = pk(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C);
            8'h41: g = pk(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
            8'h42: g = pk(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E);
            8'h43: g = pk(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E);
            8'h44: g = pk(5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C);
            8'h45: g = pk(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
            8'h46: g = pk(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10);
            8'h47: g = pk(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E);
            8'h48: g = pk(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
            8'h49: g = pk(5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
            8'h4B: g = pk(5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11);
            8'h4C: g = pk(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
            8'h4D: g = pk(5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11);
            8'h4E: g = pk(5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11);
            8'h4F: g = pk(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
            8'h50: g = pk(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
            8'h52: g = pk(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
            8'h53: g = pk(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E);
            8'h54: g = pk(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
            8'h55: g = pk(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
            8'h56: g = pk(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
            8'h57: g = pk(5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A);
            8'h58: g = pk(5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11);
            8'h59: g = pk(5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04);
            8'h61: g = pk(5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F);
            8'h62: g = pk(5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h19, 5'h16);
            8'h63: g = pk(5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E);
            8'h64: g = pk(5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h13, 5'h0D);
            8'h65: g = pk(5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E);
            8'h66: g = pk(5'h06, 5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08);
            8'h67: g = pk(5'h00, 5'h00, 5'h0D, 5'h13, 5'h13, 5'h0D, 5'h01);
            8'h68: g = pk(5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11);
            8'h69: g = pk(5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E);
            8'h6B: g = pk(5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11);
            8'h6C: g = pk(5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
            8'h6D: g = pk(5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15);
            8'h6E: g = pk(5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11);
            8'h6F: g = pk(5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E);
            8'h70: g = pk(5'h00, 5'h00, 5'h16, 5'h19, 5'h19, 5'h16, 5'h10);
            8'h72: g = pk(5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10);
            8'h73: g = pk(5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E);
            8'h74: g = pk(5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08, 5'h06);
            8'h75: g = pk(5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D);
            8'h76: g = pk(5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
            8'h77: g = pk(5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A);
            8'h78: g = pk(5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11);
            8'h79: g = pk(5'h00, 5'h00, 5'h11, 5'h13, 5'h0D, 5'h01, 5'h0E);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

[rtl/tccr_front.sv]
// Front end of the text console cell renderer: accepts commands, tracks the cursor
// and pushes one queued operation per command that yields results. Depends on tccr_pkg.
module tccr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tccr_pkg::cfg_t       cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,     // char_code[7:0]
    input  logic                 s_tuser,     // mode
    input  logic                 q_full,
    output logic                 q_push,
    output tccr_pkg::cmd_t       q_cmd
);
    import tccr_pkg::*;

    logic [7:0] col_reg, col_next;
    logic [7:0] line_reg, line_next;
    logic       accept;
    logic       at_last_row;
    logic [7:0] draw_col;
    logic [7:0] draw_line;
    logic       wrap_scroll;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign at_last_row = ({1'b0, line_reg} + 9'd1) >= {1'b0, cfg.row_count};

    // Wrap first when the column is full; the wrap may scroll instead of stepping.
    always_comb begin
        draw_col    = col_reg;
        draw_line   = line_reg;
        wrap_scroll = 1'b0;
        if (col_reg >= cfg.column_count) begin
            draw_col = '0;
            if (at_last_row) begin
                wrap_scroll = 1'b1;
            end else begin
                draw_line = line_reg + 8'd1;
            end
        end
    end

    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        q_push    = 1'b0;
        q_cmd     = '0;
        q_cmd.col  = draw_col;
        q_cmd.row  = draw_line;
        q_cmd.code = s_tdata;
        if (accept && cfg.enable) begin
            if (s_tuser == MODE_CLEAR) begin
                col_next    = '0;
                line_next   = '0;
                q_push      = 1'b1;
                q_cmd.clear = 1'b1;
            end else if (s_tdata == CHAR_CR) begin
                col_next = col_reg;
            end else if (s_tdata == CHAR_LF) begin
                col_next = '0;
                if (at_last_row) begin
                    q_push       = 1'b1;
                    q_cmd.scroll = 1'b1;
                end else begin
                    line_next = line_reg + 8'd1;
                end
            end else begin
                q_push       = 1'b1;
                q_cmd.draw   = 1'b1;
                q_cmd.scroll = wrap_scroll;
                col_next     = draw_col + 8'd1;
                line_next    = draw_line;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

[rtl/tccr_cmd_fifo.sv]
// Short operation queue between the front and back ends of the console renderer.
// Depends on tccr_pkg for the operation type and depth.
module tccr_cmd_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tccr_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output tccr_pkg::cmd_t   head_cmd
);
    import tccr_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + FIFO_CNT_W'(1);
            2'b01:   count_next = count_reg - FIFO_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/tccr_back.sv]
// Back end of the console renderer: expands each queued operation into result
// transactions, one per cycle while the result channel is not stalled, through an output register. Depends on tccr_pkg.
module tccr_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  tccr_pkg::cmd_t         q_cmd,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output tccr_pkg::result_t      m_result
);
    import tccr_pkg::*;

    logic        active_reg, active_next;
    logic        scroll_reg, scroll_next;
    logic        draw_reg, draw_next;
    logic        clear_reg, clear_next;
    logic [3:0]  line_reg, line_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [11:0] px_reg, px_next;
    logic [11:0] py_base_reg, py_base_next;
    glyph_t      glyph_reg, glyph_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    result_t     res;
    logic        out_free;
    logic        emit;
    logic        done;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = active_reg && out_free;
    assign done     = emit && res.last;
    // Load the next operation in the cycle the current one issues its last result.
    assign q_pop    = q_valid && (!active_reg || done);

    always_comb begin
        res = '0;
        if (scroll_reg) begin
            res.kind = KIND_SCROLL;
            res.last = !draw_reg;
        end else if (clear_reg) begin
            res.kind = KIND_CLEAR;
            res.last = 1'b1;
        end else begin
            res.kind       = KIND_DRAW;
            res.cell_col   = col_reg;
            res.cell_row   = row_reg;
            res.pixel_x    = px_reg;
            res.pixel_y    = py_base_reg + 12'(line_reg);
            res.line_index = line_reg;
            res.row_bits   = (line_reg < 4'(GLYPH_ROWS)) ? glyph_reg[line_reg[2:0]] : '0;
            res.last       = (line_reg == 4'(NUM_LINES - 1));
        end
    end

    always_comb begin
        active_next  = active_reg;
        scroll_next  = scroll_reg;
        draw_next    = draw_reg;
        clear_next   = clear_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        px_next      = px_reg;
        py_base_next = py_base_reg;
        glyph_next   = glyph_reg;
        if (emit) begin
            if (scroll_reg) begin
                scroll_next = 1'b0;
            end else begin
                line_next = line_reg + 4'd1;
            end
        end
        if (q_pop) begin
            active_next  = 1'b1;
            scroll_next  = q_cmd.scroll;
            draw_next    = q_cmd.draw;
            clear_next   = q_cmd.clear;
            line_next    = '0;
            col_next     = q_cmd.col;
            row_next     = q_cmd.row;
            px_next      = 12'(LEFT_MARGIN_PX) + 12'(q_cmd.col) * 12'(CELL_W);
            py_base_next = 12'(TOP_MARGIN_PX) + 12'(q_cmd.row) * 12'(CELL_H);
            glyph_next   = glyph_lookup(q_cmd.code);
        end else if (done) begin
            active_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scroll_reg  <= scroll_next;
        draw_reg    <= draw_next;
        clear_reg   <= clear_next;
        line_reg    <= line_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        px_reg      <= px_next;
        py_base_reg <= py_base_next;
        glyph_reg   <= glyph_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

[rtl/text_console_cell_renderer_core.sv]
// Top level of the text console cell renderer: configuration registers, front end,
// operation queue and back end. Depends on tccr_pkg, tccr_front, tccr_cmd_fifo, tccr_back.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------------
//  s_*      | in        | tuser = mode, tdata = char_code
//  m_*      | out       | tuser = kind, tdata = cell/pixel fields, tlast = last
//  cfg_*    | in        | write-only: console_enable, column_count, row_count
//
// A printable character issues 10 result transactions, 11 when it wraps onto a scroll;
// the back end's output register issues one result per cycle while the result channel
// is not stalled. Clear and scroll issue one; carriage return, a newline that only
// steps the row, and any command while disabled issue none.
// The front end accepts while the two-entry queue has room, also while a result waits.
// Reset is synchronous: cursor home, queue empty, registers at 0 / 1 / 1.
// A stalled result channel holds the output register and backs up into the queue.
module text_console_cell_renderer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tccr_pkg::S_TDATA_W-1:0]     s_tdata,   // char_code[7:0]
    input  logic                               s_tuser,   // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cell_col[7:0], cell_row[15:8], pixel_x[27:16], pixel_y[39:28],
    // line_index[43:40], row_bits[48:44], zero[55:49]
    output logic [tccr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                         m_tuser,   // kind
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [tccr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tccr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tccr_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full;
    logic    q_push;
    cmd_t    q_push_cmd;
    logic    q_pop;
    logic    q_valid;
    cmd_t    q_head;
    result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.column_count <= 8'd1;
            cfg_reg.row_count    <= 8'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CONSOLE_ENABLE: cfg_reg.enable       <= cfg_wdata[0];
                CFG_COLUMN_COUNT:   cfg_reg.column_count <= cfg_wdata;
                CFG_ROW_COUNT:      cfg_reg.row_count    <= cfg_wdata;
                default:            cfg_reg              <= cfg_reg;
            endcase
        end
    end

    tccr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    tccr_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    tccr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tuser = result.kind;
    assign m_tlast = result.last;
    assign m_tdata = {7'd0, result.row_bits, result.line_index, result.pixel_y,
                      result.pixel_x, result.cell_row, result.cell_col};

endmodule

[rtl/tccr_checker.sv]
// Port-level checks for the text console cell renderer, bound to the top level.
// Depends on tccr_pkg and text_console_cell_renderer_core.
module tccr_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [tccr_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [1:0]                         m_tuser,
    input  logic                               m_tlast
);
    import tccr_pkg::*;

    // Hold a stalled result transaction.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result transaction changed");

    a_nondraw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_DRAW |-> m_tdata == '0)
        else $error("scroll or clear transaction carries cell data");

    a_clear_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_CLEAR |-> m_tlast)
        else $error("clear transaction not marked last");

    a_draw_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DRAW |->
            m_tlast == (m_tdata[43:40] == 4'(NUM_LINES - 1)))
        else $error("draw transaction last flag does not match final cell line");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind text_console_cell_renderer_core tccr_checker u_tccr_checker (.*);

[dv/text_console_cell_renderer_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of text_console_cell_renderer_core: drives console commands and
// register writes, predicts every cell row, scroll and clear transaction and compares them.
// Depends on tccr_pkg and the RTL of the block.
module text_console_cell_renderer_core_tb;
    import tccr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 285;
    localparam int IDLE_PCT      = 11;
    localparam int MAX_REPORTS   = 40;

    // Cursor tracker: mirrors the registers and cursor and holds the rows still due.
    class console_tracker;
        logic       enable;
        logic [7:0] n_cols;
        logic [7:0] n_rows;
        logic [7:0] cur_col;
        logic [7:0] cur_row;
        result_t    due_rows[$];
        int         errors;

        function new();
            enable  = 1'b0;
            n_cols  = 8'd1;
            n_rows  = 8'd1;
            cur_col = '0;
            cur_row = '0;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            case (idx)
                CFG_CONSOLE_ENABLE: enable = value[0];
                CFG_COLUMN_COUNT:   n_cols = value;
                CFG_ROW_COUNT:      n_rows = value;
                default: ;
            endcase
        endfunction

        // Seven rows of a glyph, one byte each, first row in the top byte.
        function logic [55:0] glyph_bits(logic [7:0] code);
            logic [55:0] g;
            case (code)
                "-": g = 56'h0000000E000000;  ".": g = 56'h00000000000C0C;
                ":": g = 56'h000C0C000C0C00;  "/": g = 56'h02020404080810;
                "=": g = 56'h001E001E000000;  "_": g = 56'h0000000000001F;
                "0": g = 56'h0E11131519110E;  "1": g = 56'h040C040404040E;
                "2": g = 56'h0E11010204081F;  "3": g = 56'h1E01010E01011E;
                "4": g = 56'h02060A121F0202;  "5": g = 56'h1F10101E01011E;
                "6": g = 56'h0608101E11110E;  "7": g = 56'h1F010204080808;
                "8": g = 56'h0E11110E11110E;  "9": g = 56'h0E11110F01021C;
                "A": g = 56'h0E11111F111111;  "B": g = 56'h1E11111E11111E;
                "C": g = 56'h0E11101010110E;  "D": g = 56'h1C12111111121C;
                "E": g = 56'h1F10101E10101F;  "F": g = 56'h1F10101E101010;
                "G": g = 56'h0E11101711110E;  "H": g = 56'h1111111F111111;
                "I": g = 56'h0E04040404040E;  "K": g = 56'h11121418141211;
                "L": g = 56'h1010101010101F;  "M": g = 56'h111B1515111111;
                "N": g = 56'h11191513111111;  "O": g = 56'h0E11111111110E;
                "P": g = 56'h1E11111E101010;  "R": g = 56'h1E11111E141211;
                "S": g = 56'h0F10100E01011E;  "T": g = 56'h1F040404040404;
                "U": g = 56'h1111111111110E;  "V": g = 56'h11111111110A04;
                "W": g = 56'h1111111515150A;  "X": g = 56'h11110A040A1111;
                "Y": g = 56'h11110A04040404;  "a": g = 56'h00000E010F110F;
                "b": g = 56'h10101619111916;  "c": g = 56'h00000E1010100E;
                "d": g = 56'h01010D1311130D;  "e": g = 56'h00000E111F100E;
                "f": g = 56'h0608081E080808;  "g": g = 56'h00000D13130D01;
                "h": g = 56'h10101619111111;  "i": g = 56'h04000C0404040E;
                "k": g = 56'h10121418141211;  "l": g = 56'h0C04040404040E;
                "m": g = 56'h00001A15151515;  "n": g = 56'h00001619111111;
                "o": g = 56'h00000E1111110E;  "p": g = 56'h00001619191610;
                "r": g = 56'h00001619101010;  "s": g = 56'h00000F100E011E;
                "t": g = 56'h08081E08080806;  "u": g = 56'h0000111111130D;
                "v": g = 56'h00001111110A04;  "w": g = 56'h0000111115150A;
                "x": g = 56'h0000110A040A11;  "y": g = 56'h000011130D010E;
                default: g = '0;
            endcase
            return g;
        endfunction

        function void push_row(logic [1:0] kind, logic [7:0] col, logic [7:0] row,
                               logic [11:0] px, logic [11:0] py, logic [3:0] ln,
                               logic [4:0] bits, logic last);
            result_t r;
            r.kind       = kind;
            r.cell_col   = col;
            r.cell_row   = row;
            r.pixel_x    = px;
            r.pixel_y    = py;
            r.line_index = ln;
            r.row_bits   = bits;
            r.last       = last;
            due_rows.push_back(r);
        endfunction

        // Return to column 0; step the row or scroll when already on the last row.
        function void line_feed(logic is_last);
            cur_col = '0;
            if (int'(cur_row) + 1 < int'(n_rows))
                cur_row = cur_row + 8'd1;
            else
                push_row(KIND_SCROLL, '0, '0, '0, '0, '0, '0, is_last);
        endfunction

        function void accept_command(logic mode, logic [7:0] code);
            logic [55:0] glyph;
            logic [4:0]  bits;
            if (!enable)
                return;
            if (mode == MODE_CLEAR) begin
                cur_col = '0;
                cur_row = '0;
                push_row(KIND_CLEAR, '0, '0, '0, '0, '0, '0, 1'b1);
                return;
            end
            if (code == CHAR_CR)
                return;
            if (code == CHAR_LF) begin
                line_feed(1'b1);
                return;
            end
            if (cur_col >= n_cols)
                line_feed(1'b0);
            glyph = glyph_bits(code);
            for (int ln = 0; ln < NUM_LINES; ln++) begin
                bits = (ln < GLYPH_ROWS) ? glyph[8*(6-ln) +: 5] : 5'd0;
                push_row(KIND_DRAW, cur_col, cur_row,
                         12'(LEFT_MARGIN_PX + int'(cur_col) * CELL_W),
                         12'(TOP_MARGIN_PX + int'(cur_row) * CELL_H + ln),
                         4'(ln), bits, ln == NUM_LINES - 1);
            end
            cur_col = cur_col + 8'd1;
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            if (errors < MAX_REPORTS)
                $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task compare_output(result_t got, logic [6:0] pad);
            result_t want;
            if (due_rows.size() == 0) begin
                report("result with nothing due (kind)", got.kind, 0);
                return;
            end
            want = due_rows.pop_front();
            if (got.kind != want.kind)             report("kind", got.kind, want.kind);
            if (got.cell_col != want.cell_col)     report("cell_col", got.cell_col, want.cell_col);
            if (got.cell_row != want.cell_row)     report("cell_row", got.cell_row, want.cell_row);
            if (got.pixel_x != want.pixel_x)       report("pixel_x", got.pixel_x, want.pixel_x);
            if (got.pixel_y != want.pixel_y)       report("pixel_y", got.pixel_y, want.pixel_y);
            if (got.line_index != want.line_index)
                report("line_index", got.line_index, want.line_index);
            if (got.row_bits != want.row_bits)     report("row_bits", got.row_bits, want.row_bits);
            if (got.last != want.last)             report("tlast", got.last, want.last);
            if (pad != '0)                         report("tdata padding", pad, 0);
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = MODE_WRITE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic           steady = 1'b0;   // no idling on either side while set
    int             cycle_count = 0;
    result_t        seen_row;
    console_tracker tracker = new();

    string glyph_set = "-.:/=_0123456789ABCDEFGHIKLMNOPRSTUVWXYabcdefghiklmnoprstuvwxy ";

    text_console_cell_renderer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check each transaction, then pick this cycle's ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_row.kind       = m_tuser;
            seen_row.cell_col   = m_tdata[7:0];
            seen_row.cell_row   = m_tdata[15:8];
            seen_row.pixel_x    = m_tdata[27:16];
            seen_row.pixel_y    = m_tdata[39:28];
            seen_row.line_index = m_tdata[43:40];
            seen_row.row_bits   = m_tdata[48:44];
            seen_row.last       = m_tlast;
            tracker.compare_output(seen_row, m_tdata[55:49]);
        end
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_command(input logic mode, input logic [7:0] code);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.accept_command(mode, code);
    endtask

    // Drop valid, drain every due row, then let the pipeline go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.due_rows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_reg(idx, value);
    endtask

    task automatic configure(input logic en, input logic [7:0] cols, input logic [7:0] rows);
        settle();
        write_reg(CFG_CONSOLE_ENABLE, {7'd0, en});
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_ROW_COUNT, rows);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int         random_sent;
        int         phase;
        int         burst;
        int         pick;
        logic       en;
        logic [7:0] cols;
        logic [7:0] rows;
        logic [7:0] code;

        random_sent = 0;
        phase       = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Disabled after reset: everything is dropped.
        send_command(MODE_CLEAR, 8'hFF);
        send_command(MODE_WRITE, "A");
        send_command(MODE_WRITE, CHAR_LF);

        // Enable only, so one column and one row come from reset.
        settle();
        write_reg(CFG_CONSOLE_ENABLE, 8'd1);
        cfg_wr_en <= 1'b0;
        send_command(MODE_WRITE, "A");
        send_command(MODE_WRITE, "B");
        send_command(MODE_WRITE, CHAR_LF);
        send_command(MODE_WRITE, CHAR_CR);

        // Unknown bytes, wrap without scroll, newline scroll on the last row.
        configure(1'b1, 8'd3, 8'd2);
        send_command(MODE_CLEAR, 8'h00);
        send_command(MODE_WRITE, "Q");
        send_command(MODE_WRITE, 8'h00);
        send_command(MODE_WRITE, 8'hFF);
        send_command(MODE_WRITE, "y");
        send_command(MODE_WRITE, CHAR_LF);
        send_command(MODE_WRITE, CHAR_CR);
        send_command(MODE_WRITE, "_");
        send_command(MODE_CLEAR, 8'hFF);

        // Zero counts: wrap before every character, scroll on every newline.
        configure(1'b1, 8'd0, 8'd0);
        send_command(MODE_WRITE, "8");
        send_command(MODE_WRITE, "M");
        send_command(MODE_WRITE, CHAR_LF);

        // Widest console, then shrink it under a cursor that sits below the last row.
        configure(1'b1, 8'd255, 8'd255);
        send_command(MODE_WRITE, "0");
        send_command(MODE_WRITE, CHAR_LF);
        send_command(MODE_WRITE, CHAR_LF);
        send_command(MODE_WRITE, CHAR_LF);
        configure(1'b1, 8'd255, 8'd2);
        send_command(MODE_WRITE, "g");
        send_command(MODE_WRITE, CHAR_LF);

        while (random_sent < RANDOM_ITEMS) begin
            en = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 5))
                0:       cols = 8'd1;
                1:       cols = 8'd255;
                2:       cols = 8'd0;
                default: cols = 8'($urandom_range(2, 24));
            endcase
            case ($urandom_range(0, 5))
                0:       rows = 8'd1;
                1:       rows = 8'd255;
                2:       rows = 8'd0;
                default: rows = 8'($urandom_range(2, 5));
            endcase
            configure(en, cols, rows);
            steady <= (phase == 2);
            burst = $urandom_range(20, 45);
            for (int i = 0; i < burst && random_sent < RANDOM_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    send_command(MODE_WRITE, glyph_set[$urandom_range(0, glyph_set.len() - 1)]);
                else if (pick < 70)
                    send_command(MODE_WRITE, 8'($urandom_range(8'h20, 8'h7E)));
                else if (pick < 80) begin
                    code = 8'($urandom_range(0, 255));
                    send_command(MODE_WRITE, code);
                end else if (pick < 90)
                    send_command(MODE_WRITE, CHAR_LF);
                else if (pick < 95)
                    send_command(MODE_WRITE, CHAR_CR);
                else
                    send_command(MODE_CLEAR, 8'($urandom_range(0, 255)));
                random_sent++;
            end
            phase++;
        end

        steady <= 1'b0;
        settle();
        if (tracker.errors == 0 && tracker.due_rows.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[text_console_cell_renderer_core.f]
rtl/tccr_pkg.sv
rtl/tccr_front.sv
rtl/tccr_cmd_fifo.sv
rtl/tccr_back.sv
rtl/text_console_cell_renderer_core.sv
rtl/tccr_checker.sv
dv/text_console_cell_renderer_core_tb.sv
